// File: hdl/bmm_pkg.sv
package bmm_pkg;

  localparam int WEIGHT_DEPTH = 4096;
  localparam int WEIGHT_AW    = 12;
  localparam int MASK_DEPTH   = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PW     = 2;
  localparam int SUM_W        = 54;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_MASK   = 2'd1;
  localparam logic [1:0] OP_VECTOR = 2'd2;
  localparam logic [1:0] OP_RUN    = 2'd3;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_MASK  = 2'd2;
  localparam logic [1:0] CFG_SCALE = 2'd3;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WEIGHT,
    CMD_MASK,
    CMD_VECTOR,
    CMD_RUN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [11:0] index;
    logic [7:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  rows;
    logic [6:0]  cols;
    logic        mask_en;
    logic [31:0] scale;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWS,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } back_state_e;

endpackage

// File: hdl/block_masked_int8_matvec_top.sv
// Block-masked int8 matrix-vector multiply with fixed-point output scaling.
// Input beats on the slave stream carry the opcode in tuser: weight loads,
// mask byte loads, vector entry loads and run commands. Beats go through a
// four-entry command queue, so loads are taken one per cycle while the
// back end is free, and the slave side keeps accepting while a run is busy
// until the queue fills.
// A run emits one master beat per column, in column order, with tlast on
// the final column. Each column walks the rows through the single weight
// memory port at one row per cycle, then steps through the drain, scale
// and emit states before its result is registered.
// The result sits in an output register, so the next column is computed
// while the previous one waits; a stalled receiver holds the back end only
// when a new column is ready and the output register is still full.
// Configuration registers are written through the plain write port; the
// user must write them only while the block is idle (not enforced).
// Reset empties the queue, drops any pending result and restores the
// register defaults; the stores hold no defined contents until written.
module block_masked_int8_matvec_top
  import bmm_pkg::*;
#(
  parameter int MAX_IN     = 64,
  parameter int MAX_OUT    = 64,
  parameter int BLOCK_ROWS = 8,
  parameter int BLOCK_COLS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // index [11:0], signed_value [19:12], mask_byte [27:20]
  input  logic [31:0] s_axis_tdata_i,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // column [5:0], scaled_sum [59:6]
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  cfg_t                     cfg_q;
  cmd_t                     front_cmd, queue_cmd;
  logic                     front_keep, queue_full, queue_valid, queue_pop;
  logic [5:0]               res_column;
  logic signed [SUM_W-1:0]  res_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows    <= 7'd64;
      cfg_q.cols    <= 7'd64;
      cfg_q.mask_en <= 1'b0;
      cfg_q.scale   <= 32'd16777216;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:  cfg_q.rows    <= cfg_data_i[6:0];
        CFG_COLS:  cfg_q.cols    <= cfg_data_i[6:0];
        CFG_MASK:  cfg_q.mask_en <= cfg_data_i[0];
        CFG_SCALE: cfg_q.scale   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bmm_front #(
    .MAX_IN(MAX_IN)
  ) u_front (
    .opcode_i       (s_axis_tuser_i),
    .index_i        (s_axis_tdata_i[11:0]),
    .signed_value_i (s_axis_tdata_i[19:12]),
    .mask_byte_i    (s_axis_tdata_i[27:20]),
    .cmd_o          (front_cmd),
    .keep_o         (front_keep)
  );

  assign s_axis_tready_o = !queue_full;

  bmm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i && front_keep),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .data_o      (queue_cmd)
  );

  bmm_back #(
    .MAX_IN    (MAX_IN),
    .MAX_OUT   (MAX_OUT),
    .BLOCK_ROWS(BLOCK_ROWS),
    .BLOCK_COLS(BLOCK_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_column_o (res_column),
    .out_sum_o    (res_sum),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, res_sum, res_column};

endmodule

// File: hdl/bmm_front.sv
module bmm_front
  import bmm_pkg::*;
#(
  parameter int MAX_IN = 64
) (
  input  logic [1:0]  opcode_i,
  input  logic [11:0] index_i,
  input  logic [7:0]  signed_value_i,
  input  logic [7:0]  mask_byte_i,
  output cmd_t        cmd_o,
  output logic        keep_o
);

  always_comb begin
    cmd_o.index = index_i;
    cmd_o.value = signed_value_i;
    case (opcode_i)
      OP_WEIGHT: cmd_o.kind = CMD_WEIGHT;
      OP_MASK: begin
        cmd_o.value = mask_byte_i;
        cmd_o.kind  = (index_i < 12'(MASK_DEPTH)) ? CMD_MASK : CMD_NOP;
      end
      OP_VECTOR: cmd_o.kind = ({1'b0, index_i} < 13'(MAX_IN)) ? CMD_VECTOR : CMD_NOP;
      OP_RUN: cmd_o.kind = CMD_RUN;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

  assign keep_o = (cmd_o.kind != CMD_NOP);

endmodule

// File: hdl/bmm_queue.sv
module bmm_queue
  import bmm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PW:0]    count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_PW + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/bmm_back.sv
module bmm_back
  import bmm_pkg::*;
#(
  parameter int MAX_IN     = 64,
  parameter int MAX_OUT    = 64,
  parameter int BLOCK_ROWS = 8,
  parameter int BLOCK_COLS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [5:0]              out_column_o,
  output logic signed [SUM_W-1:0] out_sum_o,
  output logic                    out_last_o
);

  localparam int RCW = $clog2(MAX_IN + 1);
  localparam int CCW = $clog2(MAX_OUT + 1);
  localparam int VAW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int BRW = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int BCW = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
  localparam int ACW = $clog2(MAX_IN) + 16;
  localparam int PW  = ACW + 33;
  localparam int EW  = (PW > SUM_W) ? PW : SUM_W + 1;
  localparam logic signed [EW-1:0] SAT_HI = {{(EW - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = {{(EW - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

  function automatic logic [5:0] block_cols(input logic [CCW-1:0] n);
    logic [5:0] b;
    b = '0;
    for (int j = 0; j <= MAX_OUT; j++) begin
      if (n == CCW'(j)) begin
        b = 6'((j + BLOCK_COLS - 1) / BLOCK_COLS);
      end
    end
    return b;
  endfunction

  logic signed [7:0]     wmem [WEIGHT_DEPTH];
  logic signed [7:0]     vmem [MAX_IN];
  logic [7:0]            mask_q [MASK_DEPTH];

  back_state_e           state_q, state_d;
  logic                  pop, start, issue, emit;

  logic [RCW-1:0]        rows_w;
  logic [CCW-1:0]        cols_w;
  logic [5:0]            bcols_w;
  logic                  last_row, last_col;

  logic [RCW-1:0]        r_q;
  logic [BRW-1:0]        rin_q;
  logic [5:0]            rbase_q;
  logic [CCW-1:0]        c_q;
  logic [BCW-1:0]        cin_q;
  logic [5:0]            cb_q;
  logic [WEIGHT_AW-1:0]  waddr_q;

  logic [5:0]            bid;
  logic [7:0]            mbyte;
  logic                  keep;
  logic                  p1_valid_q, p1_keep_q;
  logic signed [7:0]     w_rd_q, v_rd_q;
  logic signed [ACW-1:0] acc_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [EW-1:0]  prod_ext;
  logic signed [SUM_W-1:0] sat_w;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    if (cfg_i.rows == '0) begin
      rows_w = RCW'(1);
    end else if ({2'b00, cfg_i.rows} > 9'(MAX_IN)) begin
      rows_w = RCW'(MAX_IN);
    end else begin
      rows_w = RCW'(cfg_i.rows);
    end
    if (cfg_i.cols == '0) begin
      cols_w = CCW'(1);
    end else if (cfg_i.cols > 7'(MAX_OUT)) begin
      cols_w = CCW'(MAX_OUT);
    end else begin
      cols_w = CCW'(cfg_i.cols);
    end
  end

  assign bcols_w  = block_cols(cols_w);
  assign last_row = ((r_q + RCW'(1)) == rows_w);
  assign last_col = ((c_q + CCW'(1)) == cols_w);

  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    start   = 1'b0;
    issue   = 1'b0;
    emit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop = 1'b1;
          if (cmd_i.kind == CMD_RUN) begin
            start   = 1'b1;
            state_d = ST_ROWS;
          end
        end
      end
      ST_ROWS: begin
        issue = 1'b1;
        if (last_row) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = last_col ? ST_IDLE : ST_ROWS;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p1_valid_q  <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      case (cmd_i.kind)
        CMD_WEIGHT: wmem[cmd_i.index] <= cmd_i.value;
        CMD_VECTOR: vmem[cmd_i.index[VAW-1:0]] <= cmd_i.value;
        CMD_MASK:   mask_q[cmd_i.index[2:0]] <= cmd_i.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    w_rd_q <= wmem[waddr_q];
    v_rd_q <= vmem[r_q[VAW-1:0]];
  end

  assign bid   = rbase_q + cb_q;
  assign mbyte = mask_q[bid[5:3]];
  assign keep  = !cfg_i.mask_en || mbyte[bid[2:0]];

  always_ff @(posedge clk_i) begin
    p1_keep_q <= keep;
    if (start) begin
      c_q     <= '0;
      cin_q   <= '0;
      cb_q    <= '0;
      r_q     <= '0;
      rin_q   <= '0;
      rbase_q <= '0;
      waddr_q <= '0;
      acc_q   <= '0;
    end else if (issue) begin
      r_q     <= r_q + RCW'(1);
      waddr_q <= waddr_q + WEIGHT_AW'(cols_w);
      if (rin_q == BRW'(BLOCK_ROWS - 1)) begin
        rin_q   <= '0;
        rbase_q <= rbase_q + bcols_w;
      end else begin
        rin_q <= rin_q + BRW'(1);
      end
    end else if (emit && !last_col) begin
      c_q     <= c_q + CCW'(1);
      r_q     <= '0;
      rin_q   <= '0;
      rbase_q <= '0;
      waddr_q <= WEIGHT_AW'(c_q + CCW'(1));
      acc_q   <= '0;
      if (cin_q == BCW'(BLOCK_COLS - 1)) begin
        cin_q <= '0;
        cb_q  <= cb_q + 6'd1;
      end else begin
        cin_q <= cin_q + BCW'(1);
      end
    end
    if (p1_valid_q && p1_keep_q) begin
      acc_q <= acc_q + ACW'(v_rd_q * w_rd_q);
    end
    prod_q <= acc_q * $signed({1'b0, cfg_i.scale});
  end

  assign prod_ext = EW'(prod_q);

  always_comb begin
    if (prod_ext > SAT_HI) begin
      sat_w = SAT_HI[SUM_W-1:0];
    end else if (prod_ext < SAT_LO) begin
      sat_w = SAT_LO[SUM_W-1:0];
    end else begin
      sat_w = prod_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_column_o <= 6'(c_q);
      out_sum_o    <= sat_w;
      out_last_o   <= last_col;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: dv/block_masked_int8_matvec_top_tb.sv
`timescale 1ns / 1ps

module block_masked_int8_matvec_top_tb;
  import bmm_pkg::*;

  localparam int MAX_IN        = 64;
  localparam int MAX_OUT       = 64;
  localparam int BLOCK_ROWS    = 8;
  localparam int BLOCK_COLS    = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam longint SUM_HI    = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO    = -SUM_HI - 1;

  typedef struct packed {
    logic [5:0]       column;
    logic [SUM_W-1:0] scaled_sum;
    logic             last;
  } column_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // index [11:0], signed_value [19:12], mask_byte [27:20]
  logic [31:0] s_axis_tdata_i;
  // opcode [1:0]
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // column [5:0], scaled_sum [59:6]
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  logic [7:0]  weight_mem [WEIGHT_DEPTH];
  bit          weight_known [WEIGHT_DEPTH];
  logic [7:0]  act_mem [MAX_IN];
  bit          act_known [MAX_IN];
  logic [7:0]  keep_mem [MASK_DEPTH];
  bit          keep_known [MASK_DEPTH];
  logic [6:0]  rows_reg;
  logic [6:0]  cols_reg;
  logic        mask_en_reg;
  logic [31:0] scale_reg;

  column_result_t expected_columns [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_req = 1'b0;

  block_masked_int8_matvec_top #(
    .MAX_IN    (MAX_IN),
    .MAX_OUT   (MAX_OUT),
    .BLOCK_ROWS(BLOCK_ROWS),
    .BLOCK_COLS(BLOCK_COLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int clamp_dim(input logic [6:0] v, input int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  task automatic predict_beat(input logic [1:0] op, input logic [11:0] idx,
                              input logic [7:0] val, input logic [7:0] mbyte);
    int rows, cols, bcols, bid;
    longint acc, prod;
    logic [7:0] keep;
    column_result_t res;
    case (op)
      OP_WEIGHT: begin
        weight_mem[idx] = val;
        weight_known[idx] = 1'b1;
      end
      OP_MASK: begin
        if (idx < MASK_DEPTH) begin
          keep_mem[idx] = mbyte;
          keep_known[idx] = 1'b1;
        end
      end
      OP_VECTOR: begin
        if (idx < MAX_IN) begin
          act_mem[idx] = val;
          act_known[idx] = 1'b1;
        end
      end
      default: begin
        rows = clamp_dim(rows_reg, MAX_IN);
        cols = clamp_dim(cols_reg, MAX_OUT);
        bcols = (cols + BLOCK_COLS - 1) / BLOCK_COLS;
        for (int c = 0; c < cols; c++) begin
          acc = 0;
          for (int r = 0; r < rows; r++) begin
            bid = (r / BLOCK_ROWS) * bcols + c / BLOCK_COLS;
            keep = keep_mem[(bid >> 3) % MASK_DEPTH];
            if (!mask_en_reg || keep[bid % 8])
              acc += longint'($signed(act_mem[r])) *
                     longint'($signed(weight_mem[(r * cols + c) % WEIGHT_DEPTH]));
          end
          prod = acc * longint'({32'd0, scale_reg});
          if (prod > SUM_HI) prod = SUM_HI;
          if (prod < SUM_LO) prod = SUM_LO;
          res.column = 6'(c);
          res.scaled_sum = prod[SUM_W-1:0];
          res.last = (c == cols - 1);
          expected_columns.push_back(res);
        end
      end
    endcase
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [11:0] idx,
                           input logic [7:0] val, input logic [7:0] mbyte);
    @(negedge clk_i);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {4'd0, mbyte, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(op, idx, val, mbyte);
  endtask

  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ROWS: rows_reg = data[6:0];
      CFG_COLS: cols_reg = data[6:0];
      CFG_MASK: mask_en_reg = data[0];
      default:  scale_reg = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure_shape(input logic [6:0] rows, input logic [6:0] cols,
                                 input logic mask_en, input logic [31:0] scale);
    drain_stream();
    write_config(CFG_ROWS, {25'($urandom), rows});
    write_config(CFG_COLS, {25'($urandom), cols});
    write_config(CFG_MASK, {31'($urandom), mask_en});
    write_config(CFG_SCALE, scale);
  endtask

  // Every store entry that the next run can touch must hold a written value.
  task automatic fill_run_inputs();
    int rows, cols, addr;
    rows = clamp_dim(rows_reg, MAX_IN);
    cols = clamp_dim(cols_reg, MAX_OUT);
    for (int r = 0; r < rows; r++)
      if (!act_known[r]) send_beat(OP_VECTOR, 12'(r), 8'($urandom), 8'($urandom));
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        addr = (r * cols + c) % WEIGHT_DEPTH;
        if (!weight_known[addr])
          send_beat(OP_WEIGHT, 12'(addr), 8'($urandom), 8'($urandom));
      end
    end
    for (int m = 0; m < MASK_DEPTH; m++)
      if (!keep_known[m]) send_beat(OP_MASK, 12'(m), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_matvec();
    fill_run_inputs();
    send_beat(OP_RUN, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic reload_keep_masks();
    for (int m = 0; m < MASK_DEPTH; m++)
      send_beat(OP_MASK, 12'(m), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    write_config(CFG_ROWS, {25'h1FF_FFFF, 7'd2});
    write_config(CFG_COLS, {25'h0AA_AAAA, 7'd2});
    for (int m = 0; m < MASK_DEPTH; m++)
      send_beat(OP_MASK, 12'(m), 8'h5A, (m % 2) ? 8'hFF : 8'h00);
    send_beat(OP_MASK, 12'd8, 8'h00, 8'hFF);
    send_beat(OP_MASK, 12'hFFF, 8'hFF, 8'hFF);
    send_beat(OP_VECTOR, 12'd0, 8'h80, 8'hFF);
    send_beat(OP_VECTOR, 12'd1, 8'h7F, 8'h00);
    send_beat(OP_VECTOR, 12'd64, 8'h01, 8'hFF);
    send_beat(OP_VECTOR, 12'hFFF, 8'h01, 8'h00);
    send_beat(OP_WEIGHT, 12'd0, 8'h80, 8'hFF);
    send_beat(OP_WEIGHT, 12'd1, 8'h7F, 8'h00);
    send_beat(OP_WEIGHT, 12'd2, 8'h80, 8'hFF);
    send_beat(OP_WEIGHT, 12'd3, 8'hFF, 8'h00);
    send_beat(OP_WEIGHT, 12'hFFF, 8'h7F, 8'hFF);
    send_beat(OP_RUN, 12'hFFF, 8'hFF, 8'hFF);
    drain_stream();
    write_config(CFG_MASK, 32'h0000_0001);
    send_beat(OP_RUN, 12'd0, 8'h00, 8'h00);
  endtask

  task automatic test_config_extremes();
    reload_keep_masks();
    configure_shape(7'd64, 7'd1, 1'b0, 32'd0);
    run_matvec();
    configure_shape(7'd1, 7'd64, 1'b1, 32'hFFFF_FFFF);
    run_matvec();
    configure_shape(7'd0, 7'd0, 1'b1, 32'($urandom));
    run_matvec();
    configure_shape(7'd127, 7'd1, 1'b1, 32'h0100_0000);
    run_matvec();
    configure_shape(7'd1, 7'd127, 1'b0, 32'($urandom));
    run_matvec();
    configure_shape(7'd7, 7'd9, 1'b1, 32'h0000_0001);
    run_matvec();
  endtask

  task automatic test_backpressure();
    configure_shape(7'd8, 7'd8, 1'b0, 32'($urandom));
    fill_run_inputs();
    hold_req = 1'b1;
    send_beat(OP_RUN, 12'($urandom), 8'($urandom), 8'($urandom));
    repeat (24) begin
      if ($urandom_range(0, 1))
        send_beat(OP_WEIGHT, 12'($urandom), 8'($urandom), 8'($urandom));
      else
        send_beat(OP_VECTOR, 12'($urandom_range(0, MAX_IN - 1)), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_full_size();
    drain_stream();
    reload_keep_masks();
    configure_shape(7'd64, 7'd1, 1'b1, 32'($urandom));
    run_matvec();
    drain_stream();
    write_config(CFG_MASK, 32'd0);
    write_config(CFG_SCALE, 32'hFFFF_FFFF);
    for (int r = 0; r < MAX_IN; r++) begin
      send_beat(OP_VECTOR, 12'(r), 8'h80, 8'($urandom));
      send_beat(OP_WEIGHT, 12'(r), 8'h80, 8'($urandom));
    end
    run_matvec();
  endtask

  task automatic reconfigure_randomly();
    logic [6:0] r7, c7;
    case ($urandom_range(0, 5))
      0: begin
        r7 = 7'($urandom_range(0, 127));
        c7 = 7'($urandom_range(0, 1));
      end
      1: begin
        r7 = 7'($urandom_range(0, 1));
        c7 = 7'($urandom_range(0, 127));
      end
      default: begin
        r7 = 7'($urandom_range(1, 8));
        c7 = 7'($urandom_range(1, 8));
      end
    endcase
    write_config(CFG_ROWS, {25'($urandom), r7});
    write_config(CFG_COLS, {25'($urandom), c7});
    if ($urandom_range(0, 1)) write_config(CFG_MASK, $urandom);
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: write_config(CFG_SCALE, 32'd0);
        1: write_config(CFG_SCALE, 32'hFFFF_FFFF);
        2: write_config(CFG_SCALE, 32'h0100_0000);
        default: write_config(CFG_SCALE, $urandom);
      endcase
    end
  endtask

  // Mostly loads into the region the next run reads, then the run; a fifth of
  // the loads go anywhere, so many of them are dropped by the block.
  task automatic test_random_sequences(input int item_target);
    int sent, rows, cols, r, c;
    bit noisy;
    sent = 0;
    while (sent < item_target) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_stream();
        reconfigure_randomly();
      end
      rows = clamp_dim(rows_reg, MAX_IN);
      cols = clamp_dim(cols_reg, MAX_OUT);
      repeat ($urandom_range(0, 8)) begin
        r = $urandom_range(0, rows - 1);
        c = $urandom_range(0, cols - 1);
        noisy = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 2))
          0: send_beat(OP_WEIGHT, noisy ? 12'($urandom) : 12'((r * cols + c) % WEIGHT_DEPTH),
                       8'($urandom), 8'($urandom));
          1: send_beat(OP_VECTOR, noisy ? 12'($urandom) : 12'(r),
                       8'($urandom), 8'($urandom));
          default: send_beat(OP_MASK,
                             noisy ? 12'($urandom) : 12'($urandom_range(0, MASK_DEPTH - 1)),
                             8'($urandom), 8'($urandom));
        endcase
        if (!noisy) sent++;
      end
      run_matvec();
      sent++;
    end
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    column_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_columns.size() == 0) begin
          $error("result beat with nothing expected: column %0d", m_axis_tdata_o[5:0]);
          mismatch_count++;
        end else begin
          want = expected_columns.pop_front();
          if (m_axis_tdata_o[5:0] !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, m_axis_tdata_o[5:0]);
            mismatch_count++;
          end
          if (m_axis_tdata_o[59:6] !== want.scaled_sum) begin
            $error("scaled_sum: expected %0d, got %0d", $signed(want.scaled_sum),
                   $signed(m_axis_tdata_o[59:6]));
            mismatch_count++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROWS;
    cfg_data_i = 32'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 32'd0;
    s_axis_tuser_i = OP_WEIGHT;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    mask_en_reg = 1'b0;
    scale_reg = 32'h0100_0000;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_full_size();
    test_random_sequences(70);
    drain_stream();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    test_random_sequences(25);
    drain_stream();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bmm_pkg.sv
hdl/bmm_front.sv
hdl/bmm_queue.sv
hdl/bmm_back.sv
hdl/block_masked_int8_matvec_top.sv
dv/block_masked_int8_matvec_top_tb.sv
